FILE: rtl/fso_pkg.sv
// ----------------------------------------------------------------------------
// fso_pkg: shared types and constants of the FIR shift/offset unit
// Opcodes, register indexes, default sizes and the per-cell control group.
// ----------------------------------------------------------------------------
`default_nettype none

package fso_pkg;

  // default sizes
  localparam int unsigned TAPS_DEF        = 64;
  localparam int unsigned SAMPLE_BITS_DEF = 12;
  localparam int unsigned COEF_BITS_DEF   = 32;

  // fixed widths
  localparam int unsigned ACC_BITS    = 32;
  localparam int unsigned SHIFT_BITS  = 6;
  localparam int unsigned OFFSET_BITS = 8;
  localparam int unsigned OUT_BITS    = 8;
  localparam int unsigned IDX_BITS    = 6;
  localparam int unsigned OP_BITS     = 2;
  localparam int unsigned CFG_IDX_BITS  = 1;
  localparam int unsigned CFG_DATA_BITS = 8;

  // opcodes
  localparam logic [OP_BITS-1:0] OP_FILTER = 2'd0;
  localparam logic [OP_BITS-1:0] OP_LOAD   = 2'd1;
  localparam logic [OP_BITS-1:0] OP_CLEAR  = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_SCALE_SHIFT = 1'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_DC_OFFSET   = 1'd1;

  // reset values of the registers
  localparam logic [SHIFT_BITS-1:0]  SHIFT_RESET  = 6'd21;
  localparam logic [OFFSET_BITS-1:0] OFFSET_RESET = 8'd128;

  // broadcast control for every cell of the tap chain
  typedef struct packed {
    logic shift;  // take the previous cell's sample, or the input one at the head
    logic clear;  // zero sample and coefficient
  } cell_ctrl_t;

endpackage

`default_nettype wire

FILE: rtl/fso_cell.sv
// ----------------------------------------------------------------------------
// fso_cell: one tap of the FIR chain
// Holds one delay-line sample and one coefficient, and adds its product to
// the partial sum that passes through it toward the end of the chain.
// ----------------------------------------------------------------------------
`default_nettype none

module fso_cell
  import fso_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int unsigned COEF_BITS   = COEF_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire cell_ctrl_t             ctrl,
  input  wire logic                   load_en,
  input  wire logic [COEF_BITS-1:0]   coef_in,
  input  wire logic [SAMPLE_BITS-1:0] sample_in,
  output logic      [SAMPLE_BITS-1:0] sample_out,
  input  wire logic                   sum_valid_in,
  input  wire logic [ACC_BITS-1:0]    sum_in,
  output logic                        sum_valid_out,
  output logic      [ACC_BITS-1:0]    sum_out
);

  localparam int unsigned PROD_BITS = COEF_BITS + SAMPLE_BITS + 1;

  logic        [SAMPLE_BITS-1:0]        sample;
  logic        [COEF_BITS-1:0]          coef;
  logic signed [PROD_BITS-1:0]          prod;
  logic signed [ACC_BITS+PROD_BITS-1:0] prod_ext;

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      sample <= '0;
      coef   <= '0;
    end else begin
      if (ctrl.shift) begin
        sample <= sample_in;
      end
      if (load_en) begin
        coef <= coef_in;
      end
    end
  end

  // signed coefficient times unsigned sample, wrapped to the accumulator
  assign prod     = $signed(coef) * $signed({1'b0, sample});
  assign prod_ext = (ACC_BITS + PROD_BITS)'(prod);

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_valid_out <= 1'b0;
    end else begin
      sum_valid_out <= sum_valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (sum_valid_in) begin
      sum_out <= sum_in + prod_ext[ACC_BITS-1:0];
    end
  end

  assign sample_out = sample;

endmodule

`default_nettype wire

FILE: rtl/fir_filter_shift_offset_unit.sv
// ----------------------------------------------------------------------------
// fir_filter_shift_offset_unit: direct-form FIR filter with shift and offset
// Items arrive on the in_ channel (valid/ready). A filter item pushes its
// sample into the tap chain and yields one 8-bit result on the out_ channel;
// load items write one coefficient, clear items zero samples and
// coefficients; neither gives a result, and unused opcodes are dropped.
// A filter item is transferred in and shifts in its sample; the start
// register then launches its partial sum, which walks the chain one cell
// per cycle into the hold register and on to the output register. One filter
// item is in flight at a time: no item is taken in until its result is
// loaded into the output register. Load and clear items go back to back.
// A finished result waits in the output register while the next item is
// taken in; a stalled receiver holds the next result in a hold register and
// then holds the input side. The cfg_ port writes scale_shift (index 0) and
// dc_offset (index 1) at once; write it only while idle.
// Reset (synchronous) zeroes all samples and coefficients, sets scale_shift
// to 21 and dc_offset to 128, and empties the output.
// ----------------------------------------------------------------------------
`default_nettype none

module fir_filter_shift_offset_unit
  import fso_pkg::*;
#(
  parameter int unsigned TAPS        = TAPS_DEF,
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int unsigned COEF_BITS   = COEF_BITS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  // configuration
  input  wire logic                     cfg_we,
  input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0] cfg_data,
  // input items
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic [OP_BITS-1:0]       opcode,
  input  wire logic [SAMPLE_BITS-1:0]   sample,
  input  wire logic [IDX_BITS-1:0]      tap_index,
  input  wire logic [COEF_BITS-1:0]     tap_value,
  // results
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic      [OUT_BITS-1:0]      filtered
);

  logic [SHIFT_BITS-1:0]  scale_shift;
  logic [OFFSET_BITS-1:0] dc_offset;

  logic busy;
  logic start;
  logic in_xfer;
  logic filter_go;
  logic load_go;
  cell_ctrl_t ctrl;

  logic [SAMPLE_BITS-1:0] samp_in  [TAPS];
  logic [SAMPLE_BITS-1:0] samp_out [TAPS];
  logic [ACC_BITS-1:0]    sum      [TAPS+1];
  logic [TAPS:0]          sum_valid;
  logic [TAPS-1:0]        load_sel;

  logic                  hold_valid;
  logic [ACC_BITS-1:0]   hold_acc;
  logic                  out_load;
  logic [4:0]            shift_amt;
  logic signed [ACC_BITS-1:0] shifted;
  logic [OUT_BITS-1:0]   filtered_next;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      scale_shift <= SHIFT_RESET;
      dc_offset   <= OFFSET_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SCALE_SHIFT: scale_shift <= cfg_data[SHIFT_BITS-1:0];
        CFG_DC_OFFSET:   dc_offset   <= cfg_data[OFFSET_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign in_ready  = !busy;
  assign in_xfer   = in_valid && in_ready;
  assign filter_go = in_xfer && (opcode == OP_FILTER);
  assign load_go   = in_xfer && (opcode == OP_LOAD);

  assign ctrl.shift = filter_go;
  assign ctrl.clear = in_xfer && (opcode == OP_CLEAR);

  // launch the partial sum in the cycle after the shift so cells see new samples
  always_ff @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      start <= filter_go;
    end
  end

  assign sum[0]       = '0;
  assign sum_valid[0] = start;

  for (genvar i = 0; i < TAPS; i++) begin : g_tap
    localparam int unsigned TAP_IDX = i;

    if (i == 0) begin : g_head
      assign samp_in[i] = sample;
    end else begin : g_body
      assign samp_in[i] = samp_out[i-1];
    end

    assign load_sel[i] = load_go && (32'(tap_index) == TAP_IDX);

    fso_cell #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .COEF_BITS   (COEF_BITS)
    ) u_cell (
      .clk           (clk),
      .rst           (rst),
      .ctrl          (ctrl),
      .load_en       (load_sel[i]),
      .coef_in       (tap_value),
      .sample_in     (samp_in[i]),
      .sample_out    (samp_out[i]),
      .sum_valid_in  (sum_valid[i]),
      .sum_in        (sum[i]),
      .sum_valid_out (sum_valid[i+1]),
      .sum_out       (sum[i+1])
    );
  end

  // catch the finished sum until the output register is free
  assign out_load = hold_valid && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (sum_valid[TAPS]) begin
      hold_valid <= 1'b1;
    end else if (out_load) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sum_valid[TAPS]) begin
      hold_acc <= sum[TAPS];
    end
  end

  // shifts of 32 and above leave only sign bits, the same as 31
  assign shift_amt     = scale_shift[SHIFT_BITS-1] ? 5'd31 : scale_shift[4:0];
  assign shifted       = $signed(hold_acc) >>> shift_amt;
  assign filtered_next = shifted[OUT_BITS-1:0] + dc_offset;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (filter_go) begin
      busy <= 1'b1;
    end else if (out_load) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      filtered <= filtered_next;
    end
  end

  // at most one partial sum anywhere between launch and output
  a_single_token: assert property (@(posedge clk) disable iff (rst)
    $onehot0({sum_valid, hold_valid}))
    else $error("more than one partial sum in flight");

  a_token_busy: assert property (@(posedge clk) disable iff (rst)
    (|sum_valid || hold_valid) |-> busy)
    else $error("partial sum in flight while idle");

  a_filter_launch: assert property (@(posedge clk) disable iff (rst)
    filter_go |=> (start && busy))
    else $error("filter transfer did not launch a sum");

  a_sum_arrives: assert property (@(posedge clk) disable iff (rst)
    sum_valid[TAPS] |=> hold_valid)
    else $error("finished sum not captured");

endmodule

`default_nettype wire

FILE: tb/fir_filter_shift_offset_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fir_filter_shift_offset_unit_tb: self-checking bench of the FIR unit
// Walks a directed table (reset values, extreme samples and coefficients,
// unused opcode, clear), then random phases under several shift/offset
// settings. Each result is checked against an in-bench model or a typed value.
// ----------------------------------------------------------------------------

module fir_filter_shift_offset_unit_tb;
  import fso_pkg::*;

  localparam int unsigned TAPS = TAPS_DEF;
  localparam int unsigned SB   = SAMPLE_BITS_DEF;
  localparam int unsigned CB   = COEF_BITS_DEF;
  localparam logic [OP_BITS-1:0] OP_UNUSED = 2'd3;
  localparam int unsigned DRAIN_CYCLES = TAPS + 16;
  localparam int unsigned NUM_PHASES   = 8;
  localparam int unsigned PHASE_ITEMS  = 215;

  typedef struct {
    logic [OP_BITS-1:0]  op;
    logic [SB-1:0]       smp;
    logic [IDX_BITS-1:0] idx;
    logic [CB-1:0]       coef;
  } fir_item_t;

  typedef struct {
    fir_item_t             item;
    bit                    typed;
    logic [OUT_BITS-1:0]   typed_val;
  } stim_row_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_BITS-1:0]  cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_data;
  logic in_valid;
  logic in_ready;
  logic [OP_BITS-1:0]  opcode;
  logic [SB-1:0]       sample;
  logic [IDX_BITS-1:0] tap_index;
  logic [CB-1:0]       tap_value;
  logic out_valid;
  logic out_ready;
  logic [OUT_BITS-1:0] filtered;

  fir_filter_shift_offset_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .opcode    (opcode),
    .sample    (sample),
    .tap_index (tap_index),
    .tap_value (tap_value),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .filtered  (filtered)
  );

  // filter model state
  logic [SB-1:0]          hist_mem [TAPS];
  logic [CB-1:0]          coef_mem [TAPS];
  logic [SHIFT_BITS-1:0]  cur_shift;
  logic [OFFSET_BITS-1:0] cur_offset;

  logic [OUT_BITS-1:0] expected_filtered_q [$];
  stim_row_t           stim_table [$];

  int  errors;
  int  n_filter, n_load, n_clear, n_unused, n_checked;
  bit  burst_mode;
  bit  hold_long;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("FAILURE");
    $finish;
  end

  // Advance the model by one item; has_out tells whether a result is due.
  task automatic compute_filtered(input fir_item_t it, output bit has_out,
                                  output logic [OUT_BITS-1:0] val);
    logic [ACC_BITS-1:0] acc;
    logic [ACC_BITS-1:0] scaled;
    has_out = 1'b0;
    val = '0;
    case (it.op)
      OP_FILTER: begin
        for (int i = TAPS - 1; i > 0; i--) hist_mem[i] = hist_mem[i-1];
        hist_mem[0] = it.smp;
        acc = '0;
        for (int i = 0; i < TAPS; i++)
          acc = acc + {{(ACC_BITS-SB){1'b0}}, hist_mem[i]} * coef_mem[i];
        if (cur_shift >= 6'd32) scaled = {ACC_BITS{acc[ACC_BITS-1]}};
        else scaled = $unsigned($signed(acc) >>> cur_shift);
        val = scaled[OUT_BITS-1:0] + cur_offset;
        has_out = 1'b1;
      end
      OP_LOAD: begin
        if (it.idx < TAPS) coef_mem[it.idx] = it.coef;
      end
      OP_CLEAR: begin
        for (int i = 0; i < TAPS; i++) begin
          hist_mem[i] = '0;
          coef_mem[i] = '0;
        end
      end
      default: ;
    endcase
  endtask

  task automatic add_row(input logic [OP_BITS-1:0] op, input int unsigned smp,
                         input int unsigned idx, input logic [CB-1:0] coef,
                         input bit typed, input logic [OUT_BITS-1:0] tval);
    stim_row_t r;
    r.item.op = op;
    r.item.smp = smp[SB-1:0];
    r.item.idx = idx[IDX_BITS-1:0];
    r.item.coef = coef;
    r.typed = typed;
    r.typed_val = tval;
    stim_table.push_back(r);
  endtask

  // Offer one item, hold it until the transfer, then log its expectation.
  task automatic send_item(input fir_item_t it, input bit typed,
                           input logic [OUT_BITS-1:0] tval);
    int gap;
    bit has_out;
    logic [OUT_BITS-1:0] val;
    gap = burst_mode ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    opcode = it.op;
    sample = it.smp;
    tap_index = it.idx;
    tap_value = it.coef;
    in_valid = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    compute_filtered(it, has_out, val);
    if (has_out) expected_filtered_q.push_back(typed ? tval : val);
    case (it.op)
      OP_FILTER: n_filter++;
      OP_LOAD:   n_load++;
      OP_CLEAR:  n_clear++;
      default:   n_unused++;
    endcase
    @(negedge clk);
  endtask

  function automatic fir_item_t random_item();
    fir_item_t it;
    int pick;
    it.smp = SB'($urandom_range(0, (1 << SB) - 1));
    it.idx = IDX_BITS'($urandom_range(0, TAPS - 1));
    it.coef = $urandom;
    pick = $urandom_range(0, 99);
    if (pick < 50) it.op = OP_FILTER;
    else if (pick < 85) it.op = OP_LOAD;
    else if (pick < 88) it.op = OP_CLEAR;
    else it.op = OP_UNUSED;
    if ($urandom_range(0, 7) == 0) it.smp = $urandom_range(0, 1) ? '1 : '0;
    case ($urandom_range(0, 3))
      0: ;
      1: it.coef = 32'($urandom_range(0, 8191)) - 32'd4096;
      2: it.coef = 32'($urandom_range(0, 2097151)) - 32'd1048576;
      default: begin
        case ($urandom_range(0, 4))
          0: it.coef = 32'h7FFF_FFFF;
          1: it.coef = 32'h8000_0000;
          2: it.coef = 32'hFFFF_FFFF;
          3: it.coef = 32'h0000_0001;
          default: it.coef = '0;
        endcase
      end
    endcase
    return it;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == CFG_SCALE_SHIFT) cur_shift = data[SHIFT_BITS-1:0];
    else cur_offset = data[OFFSET_BITS-1:0];
  endtask

  // Hold until every result is back, then let the block settle.
  task automatic drain_block();
    in_valid = 1'b0;
    while (expected_filtered_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // receiver
  initial begin
    int gap;
    out_ready = 1'b0;
    wait (rst == 1'b0);
    @(negedge clk);
    forever begin
      if (hold_long) begin
        out_ready = 1'b0;
        repeat (700) @(negedge clk);
        hold_long = 1'b0;
      end
      gap = burst_mode ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
        out_ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready = 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  // result checker
  always @(posedge clk) begin
    logic [OUT_BITS-1:0] exp_val;
    if (!rst && out_valid && out_ready) begin
      if (expected_filtered_q.size() == 0) begin
        $display("%0t: unexpected result filtered=%0d", $time, filtered);
        errors++;
      end else begin
        exp_val = expected_filtered_q.pop_front();
        n_checked++;
        if (filtered !== exp_val) begin
          $display("%0t: filtered mismatch expected=%0d actual=%0d",
                   $time, exp_val, filtered);
          errors++;
        end
      end
    end
  end

  initial begin
    int phase_shift [NUM_PHASES] = '{0, 32, 63, 19, -1, 21, 40, -1};
    int phase_offset [NUM_PHASES] = '{0, 128, 255, 200, -1, 128, 129, -1};
    int guard;
    logic [SHIFT_BITS-1:0]  sh;
    logic [OFFSET_BITS-1:0] off;

    errors = 0;
    n_filter = 0;
    n_load = 0;
    n_clear = 0;
    n_unused = 0;
    n_checked = 0;
    burst_mode = 1'b0;
    hold_long = 1'b0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    opcode = '0;
    sample = '0;
    tap_index = '0;
    tap_value = '0;
    for (int i = 0; i < TAPS; i++) begin
      hist_mem[i] = '0;
      coef_mem[i] = '0;
    end
    cur_shift = SHIFT_RESET;
    cur_offset = OFFSET_RESET;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed part, reset values of shift and offset
    add_row(OP_FILTER, 4095, 0, 32'h0, 1'b1, 8'd128);
    add_row(OP_FILTER, 0, 0, 32'h0, 1'b1, 8'd128);
    add_row(OP_UNUSED, 4095, 63, 32'hFFFF_FFFF, 1'b0, 8'd0);
    add_row(OP_FILTER, 2048, 0, 32'h0, 1'b1, 8'd128);
    add_row(OP_LOAD, 0, 0, 32'h7FFF_FFFF, 1'b0, 8'd0);
    add_row(OP_LOAD, 0, 63, 32'h8000_0000, 1'b0, 8'd0);
    add_row(OP_FILTER, 4095, 0, 32'h0, 1'b0, 8'd0);
    add_row(OP_LOAD, 0, 1, 32'hFFFF_FFFF, 1'b0, 8'd0);
    add_row(OP_LOAD, 0, 2, 32'h0000_0001, 1'b0, 8'd0);
    add_row(OP_FILTER, 4095, 0, 32'h0, 1'b0, 8'd0);
    add_row(OP_FILTER, 0, 0, 32'h0, 1'b0, 8'd0);
    add_row(OP_LOAD, 0, 0, 32'h0000_1000, 1'b0, 8'd0);
    add_row(OP_FILTER, 1, 0, 32'h0, 1'b0, 8'd0);
    add_row(OP_CLEAR, 4095, 63, 32'hFFFF_FFFF, 1'b0, 8'd0);
    add_row(OP_FILTER, 4095, 0, 32'h0, 1'b1, 8'd128);
    add_row(OP_LOAD, 0, 5, 32'h4000_0000, 1'b0, 8'd0);
    for (int i = 0; i < 5; i++) add_row(OP_FILTER, 4095, 0, 32'h0, 1'b0, 8'd0);
    add_row(OP_LOAD, 0, 32, 32'hAAAA_AAAA, 1'b0, 8'd0);
    add_row(OP_LOAD, 0, 31, 32'h5555_5555, 1'b0, 8'd0);
    add_row(OP_FILTER, 4095, 0, 32'h0, 1'b0, 8'd0);
    add_row(OP_FILTER, 0, 0, 32'h0, 1'b0, 8'd0);
    foreach (stim_table[i])
      send_item(stim_table[i].item, stim_table[i].typed, stim_table[i].typed_val);

    for (int p = 0; p < NUM_PHASES; p++) begin
      drain_block();
      sh = (phase_shift[p] < 0) ? SHIFT_BITS'($urandom_range(0, 63))
                                : SHIFT_BITS'(phase_shift[p]);
      off = (phase_offset[p] < 0) ? OFFSET_BITS'($urandom_range(0, 255))
                                  : OFFSET_BITS'(phase_offset[p]);
      write_reg(CFG_SCALE_SHIFT, {{(CFG_DATA_BITS-SHIFT_BITS){1'b0}}, sh});
      write_reg(CFG_DC_OFFSET, off);
      burst_mode = (p == 3);
      // starve the output for a while so the block backs up into its input
      if (p == 5) hold_long = 1'b1;
      for (int k = 0; k < PHASE_ITEMS; k++) send_item(random_item(), 1'b0, 8'd0);
    end
    in_valid = 1'b0;
    burst_mode = 1'b0;

    guard = 0;
    while (expected_filtered_q.size() != 0 && guard < 50000) begin
      @(negedge clk);
      guard++;
    end
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (expected_filtered_q.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, expected_filtered_q.size());
      errors++;
    end

    $display("Covered %0d filter, %0d load, %0d clear and %0d unused-opcode items",
             n_filter, n_load, n_clear, n_unused);
    $display("over %0d register settings; %0d results checked, %0d errors",
             NUM_PHASES + 1, n_checked, errors);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: fir_filter_shift_offset_unit.f
rtl/fso_pkg.sv
rtl/fso_cell.sv
rtl/fir_filter_shift_offset_unit.sv
tb/fir_filter_shift_offset_unit_tb.sv
